[rtl/core/two_slope_path_loss_rx_power_macros.svh]
// ----------------------------------------------------------------------------
// two_slope_path_loss_rx_power_macros
// assertion macros shared by the received power block
// ----------------------------------------------------------------------------
`ifndef TWO_SLOPE_PATH_LOSS_RX_POWER_MACROS_SVH
`define TWO_SLOPE_PATH_LOSS_RX_POWER_MACROS_SVH

// same-cycle implication, checked out of reset
`define RPRX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RPRX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/rprx_pkg.sv]
// ----------------------------------------------------------------------------
// rprx_pkg
// constants, types and the log2 fraction table of the received power block
// ----------------------------------------------------------------------------
`default_nettype none

package rprx_pkg;

    localparam int DISTANCE_WIDTH    = 24;
    localparam int LOG_TABLE_ENTRIES = 256;
    localparam int IDX_W             = $clog2(LOG_TABLE_ENTRIES);
    localparam int FRAC_W            = 16;
    localparam int POS_W             = $clog2(DISTANCE_WIDTH);
    localparam int LOG_W             = POS_W + FRAC_W;

    localparam int CFG_W   = 24;
    localparam int CIDX_W  = 3;
    localparam int EXP_W   = 12;
    localparam int REF_W   = 16;
    localparam int SHD_W   = 16;
    localparam int TX_W    = 16;
    localparam int RX_W    = 20;

    // slope arithmetic
    localparam int DIFF_W  = LOG_W + 1;
    localparam int PROD_W  = DIFF_W + EXP_W + 1;
    localparam int SUM_W   = PROD_W + 1;
    localparam int LO_W    = 17;
    localparam int HI_W    = SUM_W - LO_W;
    localparam int K_W     = 22;
    localparam int LOK_W   = LO_W + K_W;
    localparam int HIK_W   = HI_W + K_W + 1;
    localparam int ACC_W   = HIK_W + LO_W;
    localparam int RND_SHIFT = 36;
    localparam int LOSS_W  = ACC_W - RND_SHIFT;
    localparam int SLOPE_W = LOSS_W + 1;
    localparam int TXA_W   = TX_W + 3;
    localparam int RXF_W   = SLOPE_W + 2;

    localparam int NUM_STAGES = 7;

    // log10(2) in Q0.20; ten times it, in Q2.20, is the log10 scale
    localparam int LOG10_2_Q20 = 315653;
    localparam logic [K_W-1:0] LOG10_SCALE = K_W'(10 * LOG10_2_Q20);
    localparam logic [ACC_W-1:0] RND_BIAS = ACC_W'(64'd1 << (RND_SHIFT - 1));

    // fading loss less both antenna gains, Q8.8 dB
    localparam int FADING_DB  = 50;
    localparam int TX_GAIN_DB = 3;
    localparam int RX_GAIN_DB = 9;
    localparam logic [TXA_W-1:0] OFFSET_Q8 =
        TXA_W'((FADING_DB - TX_GAIN_DB - RX_GAIN_DB) * 256);

    localparam logic signed [RXF_W-1:0] RX_MAX_F = RXF_W'(524287);
    localparam logic signed [RXF_W-1:0] RX_MIN_F = -RXF_W'(524288);
    localparam logic [RX_W-1:0] RX_MAX = RX_W'(524287);
    localparam logic [RX_W-1:0] RX_MIN = RX_W'(524288);

    localparam logic [CFG_W-1:0] NEAR_DIST_RST   = CFG_W'(256);
    localparam logic [CFG_W-1:0] MIDDLE_DIST_RST = CFG_W'(51200);
    localparam logic [EXP_W-1:0] NEAR_EXP_RST    = EXP_W'(486);
    localparam logic [EXP_W-1:0] FAR_EXP_RST     = EXP_W'(973);
    localparam logic [REF_W-1:0] REF_LOSS_RST    = REF_W'(11949);
    localparam logic [SHD_W-1:0] SHADOW_RST      = SHD_W'(973);

    typedef enum logic [CIDX_W-1:0] {
        CFG_NEAR_DIST,
        CFG_MIDDLE_DIST,
        CFG_NEAR_EXP,
        CFG_FAR_EXP,
        CFG_REF_LOSS,
        CFG_SHADOW
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SEG_NEAR,
        SEG_FIRST,
        SEG_SECOND
    } seg_t;

    typedef struct packed {
        seg_t             seg;
        logic [TXA_W-1:0] txadj;
        logic [LOG_W-1:0] ld;
        logic [LOG_W-1:0] l0;
        logic [LOG_W-1:0] l1;
    } front_t;

    typedef struct packed {
        seg_t             seg;
        logic [TXA_W-1:0] txadj;
        logic [ACC_W-1:0] acc;
    } mid_t;

    typedef logic [FRAC_W-1:0] log_tab_t [LOG_TABLE_ENTRIES];

    // log2(1 + i/entries) by repeated squaring, 16 fraction bits, truncated
    function automatic log_tab_t build_log_tab();
        log_tab_t          tab;
        logic [63:0]       v;
        logic [FRAC_W-1:0] r;
        for (int i = 0; i < LOG_TABLE_ENTRIES; i++)
        begin
            v = (64'(LOG_TABLE_ENTRIES + i) << 30) / LOG_TABLE_ENTRIES;
            r = '0;
            for (int k = 0; k < FRAC_W; k++)
            begin
                v = (v * v) >> 30;
                r = r << 1;
                if (v >= (64'd2 << 30))
                begin
                    r = r | FRAC_W'(1);
                    v = v >> 1;
                end
            end
            tab[i] = r;
        end
        return tab;
    endfunction

    localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

`default_nettype wire

[rtl/core/rprx_log2.sv]
// ----------------------------------------------------------------------------
// rprx_log2
// table based log2 of a distance, Q.16, zero maps to zero
// ----------------------------------------------------------------------------
`default_nettype none

module rprx_log2
(
    input  logic [rprx_pkg::DISTANCE_WIDTH-1:0] x,
    output logic [rprx_pkg::LOG_W-1:0]          log_val
);

    logic [rprx_pkg::POS_W-1:0]          pos;
    logic [rprx_pkg::DISTANCE_WIDTH-1:0] norm;
    logic [rprx_pkg::IDX_W-1:0]          idx;

    always_comb
    begin
        pos = '0;
        for (int b = 1; b < rprx_pkg::DISTANCE_WIDTH; b++)
        begin
            if (x[b])
            begin
                pos = b[rprx_pkg::POS_W-1:0];
            end
        end
        // leading one moved to the top, fraction bits right below it
        norm = x << (rprx_pkg::DISTANCE_WIDTH - 1 - int'(pos));
        idx  = norm[rprx_pkg::DISTANCE_WIDTH-2 -: rprx_pkg::IDX_W];
        log_val = {pos, rprx_pkg::LOG_TAB[idx]};
    end

endmodule

`default_nettype wire

[rtl/core/rprx_front.sv]
// ----------------------------------------------------------------------------
// rprx_front
// first stage: segment select, three log2 lookups, tx power less shadowing, plus the offset of fixed losses
// ----------------------------------------------------------------------------
`default_nettype none

module rprx_front
(
    input  logic                                clk,
    input  logic                                en,
    input  logic [rprx_pkg::DISTANCE_WIDTH-1:0] link_distance,
    input  logic [rprx_pkg::TX_W-1:0]           tx_power,
    input  logic [rprx_pkg::CFG_W-1:0]          near_distance,
    input  logic [rprx_pkg::CFG_W-1:0]          middle_distance,
    input  logic [rprx_pkg::SHD_W-1:0]          shadowing_loss,
    output rprx_pkg::front_t                    front
);

    logic [rprx_pkg::LOG_W-1:0]  ld;
    logic [rprx_pkg::LOG_W-1:0]  l0;
    logic [rprx_pkg::LOG_W-1:0]  l1;
    rprx_pkg::front_t            front_next;
    rprx_pkg::front_t            front_reg;

    rprx_log2 u_log_d
    (
        .x       (link_distance),
        .log_val (ld)
    );

    rprx_log2 u_log_near
    (
        .x       (near_distance),
        .log_val (l0)
    );

    rprx_log2 u_log_middle
    (
        .x       (middle_distance),
        .log_val (l1)
    );

    always_comb
    begin
        if (link_distance < near_distance)
        begin
            front_next.seg = rprx_pkg::SEG_NEAR;
        end
        else if (link_distance < middle_distance)
        begin
            front_next.seg = rprx_pkg::SEG_FIRST;
        end
        else
        begin
            front_next.seg = rprx_pkg::SEG_SECOND;
        end
        // tx - shadowing + 38 dB
        front_next.txadj = {{3{tx_power[rprx_pkg::TX_W-1]}}, tx_power}
                         - {{3{shadowing_loss[rprx_pkg::SHD_W-1]}}, shadowing_loss}
                         + rprx_pkg::OFFSET_Q8;
        front_next.ld = ld;
        front_next.l0 = l0;
        front_next.l1 = l1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

`default_nettype wire

[rtl/core/rprx_scale.sv]
// ----------------------------------------------------------------------------
// rprx_scale
// stages two to five: exponent products, slope sum, log10 scaling, rounding bias
// ----------------------------------------------------------------------------
`default_nettype none

module rprx_scale
(
    input  logic                      clk,
    input  logic [3:0]                en,
    input  rprx_pkg::front_t          front,
    input  logic [rprx_pkg::EXP_W-1:0] near_exponent,
    input  logic [rprx_pkg::EXP_W-1:0] far_exponent,
    output rprx_pkg::mid_t            mid
);

    localparam int PW = rprx_pkg::PROD_W;
    localparam int DW = rprx_pkg::DIFF_W;

    // stage two
    logic [DW-1:0]                    da;
    logic [DW-1:0]                    db;
    logic signed [PW-1:0]             pa_next;
    logic signed [PW-1:0]             pb_next;
    logic signed [PW-1:0]             pa_reg;
    logic signed [PW-1:0]             pb_reg;
    rprx_pkg::seg_t                   seg2_reg;
    logic [rprx_pkg::TXA_W-1:0]       tx2_reg;

    // stage three
    logic signed [rprx_pkg::SUM_W-1:0] sum_next;
    logic signed [rprx_pkg::SUM_W-1:0] sum_reg;
    rprx_pkg::seg_t                    seg3_reg;
    logic [rprx_pkg::TXA_W-1:0]        tx3_reg;

    // stage four
    logic [rprx_pkg::LOK_W-1:0]        lok_next;
    logic signed [rprx_pkg::HIK_W-1:0] hik_next;
    logic [rprx_pkg::LOK_W-1:0]        lok_reg;
    logic signed [rprx_pkg::HIK_W-1:0] hik_reg;
    rprx_pkg::seg_t                    seg4_reg;
    logic [rprx_pkg::TXA_W-1:0]        tx4_reg;

    // stage five
    rprx_pkg::mid_t                    mid_next;
    rprx_pkg::mid_t                    mid_reg;

    always_comb
    begin
        if (front.seg == rprx_pkg::SEG_SECOND)
        begin
            da = {1'b0, front.l1} - {1'b0, front.l0};
            db = {1'b0, front.ld} - {1'b0, front.l1};
        end
        else
        begin
            da = {1'b0, front.ld} - {1'b0, front.l0};
            db = '0;
        end
        pa_next = $signed({{(PW - DW){da[DW-1]}}, da})
                * $signed({{(PW - rprx_pkg::EXP_W){1'b0}}, near_exponent});
        pb_next = $signed({{(PW - DW){db[DW-1]}}, db})
                * $signed({{(PW - rprx_pkg::EXP_W){1'b0}}, far_exponent});
    end

    assign sum_next = $signed({pa_reg[PW-1], pa_reg}) + $signed({pb_reg[PW-1], pb_reg});

    // sum split into a low 17-bit part and a high part, each scaled by 10*log10(2)
    always_comb
    begin
        lok_next = {{(rprx_pkg::LOK_W - rprx_pkg::LO_W){1'b0}}, sum_reg[rprx_pkg::LO_W-1:0]}
                 * {{(rprx_pkg::LOK_W - rprx_pkg::K_W){1'b0}}, rprx_pkg::LOG10_SCALE};
        hik_next = $signed({{(rprx_pkg::HIK_W - rprx_pkg::HI_W){sum_reg[rprx_pkg::SUM_W-1]}},
                            sum_reg[rprx_pkg::SUM_W-1:rprx_pkg::LO_W]})
                 * $signed({{(rprx_pkg::HIK_W - rprx_pkg::K_W){1'b0}}, rprx_pkg::LOG10_SCALE});
    end

    // half away from zero: add half, less one when negative
    always_comb
    begin
        mid_next.seg   = seg4_reg;
        mid_next.txadj = tx4_reg;
        mid_next.acc   = {hik_reg, {rprx_pkg::LO_W{1'b0}}}
                       + {{(rprx_pkg::ACC_W - rprx_pkg::LOK_W){1'b0}}, lok_reg}
                       + rprx_pkg::RND_BIAS
                       - {{(rprx_pkg::ACC_W - 1){1'b0}}, hik_reg[rprx_pkg::HIK_W-1]};
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            seg2_reg <= front.seg;
            tx2_reg  <= front.txadj;
        end
        if (en[1])
        begin
            sum_reg  <= sum_next;
            seg3_reg <= seg2_reg;
            tx3_reg  <= tx2_reg;
        end
        if (en[2])
        begin
            lok_reg  <= lok_next;
            hik_reg  <= hik_next;
            seg4_reg <= seg3_reg;
            tx4_reg  <= tx3_reg;
        end
        if (en[3])
        begin
            mid_reg  <= mid_next;
        end
    end

    assign mid = mid_reg;

endmodule

`default_nettype wire

[rtl/core/rprx_back.sv]
// ----------------------------------------------------------------------------
// rprx_back
// stages six and seven: rounded slope loss, received power and saturation
// ----------------------------------------------------------------------------
`default_nettype none

module rprx_back
(
    input  logic                       clk,
    input  logic [1:0]                 en,
    input  rprx_pkg::mid_t             mid,
    input  logic [rprx_pkg::REF_W-1:0] reference_loss,
    output logic [rprx_pkg::RX_W-1:0]  rx_power,
    output logic [1:0]                 segment,
    output logic                       saturated
);

    localparam int SW = rprx_pkg::SLOPE_W;
    localparam int LW = rprx_pkg::LOSS_W;

    logic [LW-1:0]                      rnd;
    logic [SW-1:0]                      slope_next;
    logic [SW-1:0]                      slope_reg;
    rprx_pkg::seg_t                     seg6_reg;
    logic [rprx_pkg::TXA_W-1:0]         tx6_reg;

    logic signed [rprx_pkg::RXF_W-1:0]  rxf;
    logic [rprx_pkg::RX_W-1:0]          rx_next;
    logic                               sat_next;
    logic [rprx_pkg::RX_W-1:0]          rx_reg;
    rprx_pkg::seg_t                     seg_reg;
    logic                               sat_reg;

    always_comb
    begin
        rnd = mid.acc[rprx_pkg::ACC_W-1:rprx_pkg::RND_SHIFT];
        if (mid.seg == rprx_pkg::SEG_NEAR)
        begin
            slope_next = '0;
        end
        else
        begin
            slope_next = {rnd[LW-1], rnd}
                       + {{(SW - rprx_pkg::REF_W){1'b0}}, reference_loss};
        end
    end

    always_comb
    begin
        rxf = $signed({{(rprx_pkg::RXF_W - rprx_pkg::TXA_W){tx6_reg[rprx_pkg::TXA_W-1]}},
                       tx6_reg})
            - $signed({{(rprx_pkg::RXF_W - SW){slope_reg[SW-1]}}, slope_reg});
        if (rxf > rprx_pkg::RX_MAX_F)
        begin
            rx_next  = rprx_pkg::RX_MAX;
            sat_next = 1'b1;
        end
        else if (rxf < rprx_pkg::RX_MIN_F)
        begin
            rx_next  = rprx_pkg::RX_MIN;
            sat_next = 1'b1;
        end
        else
        begin
            rx_next  = rxf[rprx_pkg::RX_W-1:0];
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            slope_reg <= slope_next;
            seg6_reg  <= mid.seg;
            tx6_reg   <= mid.txadj;
        end
        if (en[1])
        begin
            rx_reg    <= rx_next;
            seg_reg   <= seg6_reg;
            sat_reg   <= sat_next;
        end
    end

    assign rx_power  = rx_reg;
    assign segment   = seg_reg;
    assign saturated = sat_reg;

endmodule

`default_nettype wire

[rtl/core/two_slope_path_loss_rx_power.sv]
// throughput: one word per cycle while out_stall is low
// the seven stage registers each hold one word
// a stage with no word or whose successor moves takes a new one, so bubbles close up
// reset clears the stage valid bits and loads the register reset values;
// the log2 table is constant logic, so there is no start-up delay
// ----------------------------------------------------------------------------
// two_slope_path_loss_rx_power
// received power over a two-slope log-distance path loss, saturating Q12.8 dBm
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_slope_path_loss_rx_power_macros.svh"

module two_slope_path_loss_rx_power
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_we,
    input  logic [rprx_pkg::CIDX_W-1:0]         cfg_index,
    input  logic [rprx_pkg::CFG_W-1:0]          cfg_data,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [rprx_pkg::DISTANCE_WIDTH-1:0] link_distance,
    input  logic [rprx_pkg::TX_W-1:0]           tx_power,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [rprx_pkg::RX_W-1:0]           rx_power,
    output logic [1:0]                          segment,
    output logic                                saturated
);

    localparam int NS = rprx_pkg::NUM_STAGES;

    logic [rprx_pkg::CFG_W-1:0] near_distance_reg;
    logic [rprx_pkg::CFG_W-1:0] middle_distance_reg;
    logic [rprx_pkg::EXP_W-1:0] near_exponent_reg;
    logic [rprx_pkg::EXP_W-1:0] far_exponent_reg;
    logic [rprx_pkg::REF_W-1:0] reference_loss_reg;
    logic [rprx_pkg::SHD_W-1:0] shadowing_loss_reg;

    logic [NS-1:0]              en;
    logic [NS-1:0]              v_reg;
    logic [NS-1:0]              v_next;

    rprx_pkg::front_t           front;
    rprx_pkg::mid_t             mid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_distance_reg   <= rprx_pkg::NEAR_DIST_RST;
            middle_distance_reg <= rprx_pkg::MIDDLE_DIST_RST;
            near_exponent_reg   <= rprx_pkg::NEAR_EXP_RST;
            far_exponent_reg    <= rprx_pkg::FAR_EXP_RST;
            reference_loss_reg  <= rprx_pkg::REF_LOSS_RST;
            shadowing_loss_reg  <= rprx_pkg::SHADOW_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rprx_pkg::CFG_NEAR_DIST:   near_distance_reg   <= cfg_data;
                rprx_pkg::CFG_MIDDLE_DIST: middle_distance_reg <= cfg_data;
                rprx_pkg::CFG_NEAR_EXP:    near_exponent_reg   <= cfg_data[rprx_pkg::EXP_W-1:0];
                rprx_pkg::CFG_FAR_EXP:     far_exponent_reg    <= cfg_data[rprx_pkg::EXP_W-1:0];
                rprx_pkg::CFG_REF_LOSS:    reference_loss_reg  <= cfg_data[rprx_pkg::REF_W-1:0];
                rprx_pkg::CFG_SHADOW:      shadowing_loss_reg  <= cfg_data[rprx_pkg::SHD_W-1:0];
                default:                   ;
            endcase
        end
    end

    // a stage loads when empty or when the stage after it moves on
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || !out_stall;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next[0] = en[0] ? in_valid : v_reg[0];
        for (int k = 1; k < NS; k++)
        begin
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = v_reg[NS-1];

    rprx_front u_front
    (
        .clk             (clk),
        .en              (en[0]),
        .link_distance   (link_distance),
        .tx_power        (tx_power),
        .near_distance   (near_distance_reg),
        .middle_distance (middle_distance_reg),
        .shadowing_loss  (shadowing_loss_reg),
        .front           (front)
    );

    rprx_scale u_scale
    (
        .clk           (clk),
        .en            (en[4:1]),
        .front         (front),
        .near_exponent (near_exponent_reg),
        .far_exponent  (far_exponent_reg),
        .mid           (mid)
    );

    rprx_back u_back
    (
        .clk            (clk),
        .en             (en[6:5]),
        .mid            (mid),
        .reference_loss (reference_loss_reg),
        .rx_power       (rx_power),
        .segment        (segment),
        .saturated      (saturated)
    );

    `RPRX_ASSERT_NOW(a_sat_at_limit, out_valid && saturated, (rx_power == rprx_pkg::RX_MAX) || (rx_power == rprx_pkg::RX_MIN), "saturated word not at a range limit")

    `RPRX_ASSERT_NOW(a_stall_only_full, in_stall, &v_reg, "input stalled while a stage is empty")

    `RPRX_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, v_reg[0], "accepted word missing from first stage")

endmodule

`default_nettype wire
